### hdl/crmp_pkg.sv
// Shared constants, codes and control types of the 5x5 conv / requant / max-pool block.
// No dependencies; every other file but crmp_if.sv refers to this package by scoped names.
package crmp_pkg;

   localparam int MAX_CHANNELS_IN  = 16;
   localparam int MAX_CHANNELS_OUT = 32;
   localparam int MAX_IMAGE_DIM    = 32;
   localparam int KERNEL_SIZE      = 5;
   localparam int TAPS             = KERNEL_SIZE * KERNEL_SIZE;
   localparam int MAX_PAD          = 2;
   localparam int PIX_MAX          = 127;
   // running weight address: co * cin * 25 + cin * 25 stays below 2**15
   localparam int WIDX_W           = 15;

   // item kinds
   localparam logic [1:0] KIND_PIXEL   = 2'd0;
   localparam logic [1:0] KIND_WEIGHT  = 2'd1;
   localparam logic [1:0] KIND_BIAS    = 2'd2;
   localparam logic [1:0] KIND_COMPUTE = 2'd3;

   // register indexes
   localparam logic [2:0] REG_IN_CHANNELS  = 3'd0;
   localparam logic [2:0] REG_IN_HEIGHT    = 3'd1;
   localparam logic [2:0] REG_IN_WIDTH     = 3'd2;
   localparam logic [2:0] REG_OUT_CHANNELS = 3'd3;
   localparam logic [2:0] REG_PAD_AMOUNT   = 3'd4;
   localparam logic [2:0] REG_POOL_ENABLE  = 3'd5;
   localparam logic [2:0] REG_SCALE_FACTOR = 3'd6;
   localparam logic [2:0] REG_SHIFT_AMOUNT = 3'd7;

   typedef struct packed {
      logic [4:0]  in_channels;
      logic [5:0]  in_height;
      logic [5:0]  in_width;
      logic [5:0]  out_channels;
      logic [1:0]  pad_amount;
      logic        pool_enable;
      logic [23:0] scale_factor;
      logic [4:0]  shift_amount;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic       write;
      logic       setup0;
      logic       setup1;
      logic       win_init;
      logic       tap;
      logic       next_plane;
      logic       mul;
      logic       requant;
      logic       first_win;
      logic       out_load;
      logic [1:0] win;
      logic [2:0] kh;
      logic [2:0] kw;
   } cmd_type;

   typedef struct packed {
      logic [4:0] cin_eff;
      logic       pool;
   } status_type;

endpackage

### hdl/crmp_if.sv
// Handshake channels of the conv block: item requests and result responses.
// Depends on nothing but the payload widths of the block's fields.
interface crmp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [13:0]        store_index;
   logic signed [15:0] write_value;
   logic [4:0]         out_channel;
   logic [4:0]         out_row;
   logic [4:0]         out_col;

   modport source (output valid, kind, store_index, write_value, out_channel, out_row,
                   out_col, input ready);
   modport sink (input valid, kind, store_index, write_value, out_channel, out_row,
                 out_col, output ready);
endinterface

interface crmp_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] pixel_out;

   modport source (output valid, pixel_out, input ready);
   modport sink (input valid, pixel_out, output ready);
endinterface

### hdl/crmp_csr.sv
// APB-style register file of the conv block.
// Uses crmp_pkg for the register indexes and the configuration struct.
module crmp_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output crmp_pkg::cfg_type  cfg
);

   crmp_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        reg_idx;
   logic              wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            crmp_pkg::REG_IN_CHANNELS:  cfg_in.in_channels  = pwdata[4:0];
            crmp_pkg::REG_IN_HEIGHT:    cfg_in.in_height    = pwdata[5:0];
            crmp_pkg::REG_IN_WIDTH:     cfg_in.in_width     = pwdata[5:0];
            crmp_pkg::REG_OUT_CHANNELS: cfg_in.out_channels = pwdata[5:0];
            crmp_pkg::REG_PAD_AMOUNT:   cfg_in.pad_amount   = pwdata[1:0];
            crmp_pkg::REG_POOL_ENABLE:  cfg_in.pool_enable  = pwdata[0];
            crmp_pkg::REG_SCALE_FACTOR: cfg_in.scale_factor = pwdata[23:0];
            crmp_pkg::REG_SHIFT_AMOUNT: cfg_in.shift_amount = pwdata[4:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         crmp_pkg::REG_IN_CHANNELS:  prdata = {27'd0, cfg_ff.in_channels};
         crmp_pkg::REG_IN_HEIGHT:    prdata = {26'd0, cfg_ff.in_height};
         crmp_pkg::REG_IN_WIDTH:     prdata = {26'd0, cfg_ff.in_width};
         crmp_pkg::REG_OUT_CHANNELS: prdata = {26'd0, cfg_ff.out_channels};
         crmp_pkg::REG_PAD_AMOUNT:   prdata = {30'd0, cfg_ff.pad_amount};
         crmp_pkg::REG_POOL_ENABLE:  prdata = {31'd0, cfg_ff.pool_enable};
         crmp_pkg::REG_SCALE_FACTOR: prdata = {8'd0, cfg_ff.scale_factor};
         crmp_pkg::REG_SHIFT_AMOUNT: prdata = {27'd0, cfg_ff.shift_amount};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_channels  <= 5'd1;
         cfg_ff.in_height    <= 6'd28;
         cfg_ff.in_width     <= 6'd28;
         cfg_ff.out_channels <= 6'd1;
         cfg_ff.pad_amount   <= 2'd0;
         cfg_ff.pool_enable  <= 1'b0;
         cfg_ff.scale_factor <= 24'd65536;
         cfg_ff.shift_amount <= 5'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/crmp_dp.sv
// Datapath of the conv block: pixel, weight and bias stores, tap address pipeline,
// multiply-accumulate, requantization and pooling max. Uses crmp_pkg; driven by crmp_ctrl.
module crmp_dp #(
   parameter int MAX_CHANNELS_IN  = crmp_pkg::MAX_CHANNELS_IN,
   parameter int MAX_CHANNELS_OUT = crmp_pkg::MAX_CHANNELS_OUT,
   parameter int MAX_IMAGE_DIM    = crmp_pkg::MAX_IMAGE_DIM
) (
   input  logic                   clock,
   input  logic                   reset,
   input  crmp_pkg::cfg_type      cfg,
   input  crmp_pkg::cmd_type      cmd,
   output crmp_pkg::status_type   status,
   input  logic [1:0]             req_kind,
   input  logic [13:0]            req_store_index,
   input  logic signed [15:0]     req_write_value,
   input  logic [4:0]             req_out_channel,
   input  logic [4:0]             req_out_row,
   input  logic [4:0]             req_out_col,
   output logic [6:0]             pixel_out
);

   localparam int IN_DEPTH = MAX_CHANNELS_IN * MAX_IMAGE_DIM * MAX_IMAGE_DIM;
   localparam int IA_W     = $clog2(IN_DEPTH);
   localparam int W_DEPTH  = MAX_CHANNELS_OUT * MAX_CHANNELS_IN * crmp_pkg::TAPS;
   localparam int WA_W     = $clog2(W_DEPTH);
   localparam int B_DEPTH  = MAX_CHANNELS_OUT;
   localparam int BA_W     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
   localparam int SUM_W    = (IA_W + 1 > 13) ? IA_W + 1 : 13;
   localparam int WIDX_W   = crmp_pkg::WIDX_W;

   logic [7:0]  in_mem [IN_DEPTH];
   logic [7:0]  w_mem  [W_DEPTH];
   logic [15:0] b_mem  [B_DEPTH];

   // effective (saturated) configuration
   logic [4:0] cin_eff;
   logic [5:0] h_eff, w_eff;
   logic [1:0] pad_eff;

   assign cin_eff = (int'(cfg.in_channels) > MAX_CHANNELS_IN) ? 5'(MAX_CHANNELS_IN)
                                                             : cfg.in_channels;
   assign h_eff   = (int'(cfg.in_height) > MAX_IMAGE_DIM) ? 6'(MAX_IMAGE_DIM) : cfg.in_height;
   assign w_eff   = (int'(cfg.in_width) > MAX_IMAGE_DIM) ? 6'(MAX_IMAGE_DIM) : cfg.in_width;
   assign pad_eff = (cfg.pad_amount > 2'(crmp_pkg::MAX_PAD)) ? 2'(crmp_pkg::MAX_PAD)
                                                            : cfg.pad_amount;

   assign status.cin_eff = cin_eff;
   assign status.pool    = cfg.pool_enable;

   // item and per-pixel setup registers
   logic [4:0]        co_ff, row_ff, col_ff;
   logic [9:0]        cowt_ff;
   logic [11:0]       hw_ff;
   logic [15:0]       bias_ff;
   logic [WIDX_W-1:0] wbase_ff, wgt_ff;
   logic [SUM_W-1:0]  plane_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         co_ff  <= req_out_channel;
         row_ff <= req_out_row;
         col_ff <= req_out_col;
      end
      if (cmd.setup0) begin
         cowt_ff <= co_ff * cin_eff;
         hw_ff   <= h_eff * w_eff;
         bias_ff <= (int'(co_ff) < B_DEPTH) ? b_mem[BA_W'(co_ff)] : 16'd0;
      end
      if (cmd.setup1) begin
         wbase_ff <= WIDX_W'(cowt_ff) * WIDX_W'(crmp_pkg::TAPS);
      end
      if (cmd.win_init) begin
         wgt_ff   <= wbase_ff;
         plane_ff <= '0;
      end else if (cmd.tap) begin
         wgt_ff <= wgt_ff + WIDX_W'(1);
         if (cmd.next_plane) begin
            plane_ff <= plane_ff + SUM_W'(hw_ff);
         end
      end
   end

   // store writes
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         if (req_kind == crmp_pkg::KIND_PIXEL && int'(req_store_index) < IN_DEPTH) begin
            in_mem[IA_W'(req_store_index)] <= req_write_value[7:0];
         end
         if (req_kind == crmp_pkg::KIND_WEIGHT && int'(req_store_index) < W_DEPTH) begin
            w_mem[WA_W'(req_store_index)] <= req_write_value[7:0];
         end
         if (req_kind == crmp_pkg::KIND_BIAS && int'(req_store_index) < B_DEPTH) begin
            b_mem[BA_W'(req_store_index)] <= req_write_value;
         end
      end
   end

   // tap stage 0: window position and bounds
   logic [6:0]        ho, wo;
   logic signed [7:0] hi, wi;
   logic              inb;

   assign ho = cfg.pool_enable ? {1'b0, row_ff, cmd.win[1]} : {2'b0, row_ff};
   assign wo = cfg.pool_enable ? {1'b0, col_ff, cmd.win[0]} : {2'b0, col_ff};
   assign hi = $signed({1'b0, ho}) + $signed({5'b0, cmd.kh}) - $signed({6'b0, pad_eff});
   assign wi = $signed({1'b0, wo}) + $signed({5'b0, cmd.kw}) - $signed({6'b0, pad_eff});
   assign inb = !hi[7] && (hi[6:0] < {1'b0, h_eff}) && !wi[7] && (wi[6:0] < {1'b0, w_eff});

   logic              s1_v_ff, s2_v_ff, s3_v_ff;
   logic              s1_inb_ff, s2_inb_ff, s2_wok_ff;
   logic [11:0]       s1_rowmul_ff;
   logic [5:0]        s1_wi_ff;
   logic [SUM_W-1:0]  s1_plane_ff;
   logic [WIDX_W-1:0] s1_waddr_ff;
   logic [7:0]        s2_ipix_ff, s2_wpix_ff;
   logic signed [15:0] s3_prod_ff;
   logic signed [31:0] acc_ff;

   logic [SUM_W-1:0] iaddr;
   assign iaddr = s1_plane_ff + SUM_W'(s1_rowmul_ff) + SUM_W'(s1_wi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.tap;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      // stage 1: row offset
      s1_inb_ff    <= inb;
      s1_rowmul_ff <= hi[5:0] * w_eff;
      s1_wi_ff     <= wi[5:0];
      s1_plane_ff  <= plane_ff;
      s1_waddr_ff  <= wgt_ff;
      // stage 2: store reads
      s2_ipix_ff <= in_mem[IA_W'(iaddr)];
      s2_wpix_ff <= w_mem[WA_W'(s1_waddr_ff)];
      s2_inb_ff  <= s1_inb_ff && (int'(iaddr) < IN_DEPTH);
      s2_wok_ff  <= int'(s1_waddr_ff) < W_DEPTH;
      // stage 3: product, padding and missing weights count as zero
      s3_prod_ff <= (s2_inb_ff && s2_wok_ff) ? $signed(s2_ipix_ff) * $signed(s2_wpix_ff)
                                             : 16'sd0;
      // stage 4: accumulate
      if (cmd.win_init) begin
         acc_ff <= 32'(signed'(bias_ff));
      end else if (s3_v_ff) begin
         acc_ff <= acc_ff + 32'(s3_prod_ff);
      end
   end

   // requantization: split the 31 x 24 product in two halves
   logic [30:0] relu;
   logic [39:0] plo_ff;
   logic [38:0] phi_ff;
   logic [39:0] scaled, shifted;
   logic [6:0]  pix;
   logic [6:0]  best_ff, pixel_ff;

   assign relu    = acc_ff[31] ? 31'd0 : acc_ff[30:0];
   assign scaled  = {1'b0, phi_ff} + {16'd0, plo_ff[39:16]};
   assign shifted = scaled >> cfg.shift_amount;
   assign pix     = (shifted > 40'(crmp_pkg::PIX_MAX)) ? 7'(crmp_pkg::PIX_MAX) : shifted[6:0];

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         plo_ff <= relu[15:0] * cfg.scale_factor;
         phi_ff <= relu[30:16] * cfg.scale_factor;
      end
      if (cmd.requant && (cmd.first_win || pix > best_ff)) begin
         best_ff <= pix;
      end
      if (cmd.out_load) begin
         pixel_ff <= best_ff;
      end
   end

   assign pixel_out = pixel_ff;

endmodule

### hdl/crmp_ctrl.sv
// Sequencer of the conv block: walks windows, input channels and kernel taps,
// and runs the handshakes. Uses crmp_pkg; commands crmp_dp.
module crmp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_kind,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  crmp_pkg::status_type  status,
   output crmp_pkg::cmd_type     cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SETUP0 = 4'd1;
   localparam logic [3:0] ST_SETUP1 = 4'd2;
   localparam logic [3:0] ST_WINIT  = 4'd3;
   localparam logic [3:0] ST_RUN    = 4'd4;
   localparam logic [3:0] ST_DRAIN  = 4'd5;
   localparam logic [3:0] ST_MUL    = 4'd6;
   localparam logic [3:0] ST_REQ    = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   localparam logic [2:0] K_LAST     = 3'(crmp_pkg::KERNEL_SIZE - 1);
   localparam logic [1:0] DRAIN_LAST = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [4:0] ci_ff, ci_in;
   logic [2:0] kh_ff, kh_in, kw_ff, kw_in;
   logic [1:0] win_ff, win_in, drain_ff, drain_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       plane_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign plane_end = (kh_ff == K_LAST) && (kw_ff == K_LAST);

   always_comb begin
      state_in = state_ff;
      ci_in    = ci_ff;
      kh_in    = kh_ff;
      kw_in    = kw_ff;
      win_in   = win_ff;
      drain_in = drain_ff;
      cmd      = '0;
      cmd.win  = win_ff;
      cmd.kh   = kh_ff;
      cmd.kw   = kw_ff;
      cmd.first_win = (win_ff == 2'd0);
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == crmp_pkg::KIND_COMPUTE) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SETUP0;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_SETUP0: begin
            cmd.setup0 = 1'b1;
            state_in   = ST_SETUP1;
         end
         ST_SETUP1: begin
            cmd.setup1 = 1'b1;
            win_in     = 2'd0;
            state_in   = ST_WINIT;
         end
         ST_WINIT: begin
            cmd.win_init = 1'b1;
            ci_in    = '0;
            kh_in    = '0;
            kw_in    = '0;
            drain_in = '0;
            state_in = (status.cin_eff == 5'd0) ? ST_DRAIN : ST_RUN;
         end
         ST_RUN: begin
            cmd.tap        = 1'b1;
            cmd.next_plane = plane_end;
            if (kw_ff == K_LAST) begin
               kw_in = '0;
               if (kh_ff == K_LAST) begin
                  kh_in = '0;
                  ci_in = ci_ff + 5'd1;
                  if (ci_ff == status.cin_eff - 5'd1) begin
                     drain_in = '0;
                     state_in = ST_DRAIN;
                  end
               end else begin
                  kh_in = kh_ff + 3'd1;
               end
            end else begin
               kw_in = kw_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to reach the accumulator
            drain_in = drain_ff + 2'd1;
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_REQ;
         end
         ST_REQ: begin
            cmd.requant = 1'b1;
            if (status.pool && win_ff != 2'd3) begin
               win_in   = win_ff + 2'd1;
               state_in = ST_WINIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ci_ff        <= '0;
         kh_ff        <= '0;
         kw_ff        <= '0;
         win_ff       <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ci_ff        <= ci_in;
         kh_ff        <= kh_in;
         kw_ff        <= kw_in;
         win_ff       <= win_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_run_channel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (ci_ff < status.cin_eff))
      else $error("tap issued past the last input channel");

   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (drain_ff <= DRAIN_LAST))
      else $error("drain counter overran");

   a_compute_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == crmp_pkg::KIND_COMPUTE)
      |=> (state_ff == ST_SETUP0))
      else $error("compute transfer did not start setup");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

endmodule

### hdl/conv5x5_relu_requant_maxpool_core.sv
// Quantized int8 5x5 convolution with ReLU, Q8.16 requantization and optional 2x2 max
// pool. Write items load pixels, weights and biases and leave the input side ready for
// the next item. A compute item keeps the input side busy through the transfer, two
// setup states, then per window (one, or four when pooling) an init state, one
// multiply-accumulate per tap, the pipeline drain and two requantization states, and a
// last state that loads the result register. The single MAC lane and the one read port
// of each store make the taps run one after another. The result register lets the next
// item in while a result waits; a compute item holds in its last state until the
// previous result has been taken.
module conv5x5_relu_requant_maxpool_core #(
   parameter int MAX_CHANNELS_IN  = crmp_pkg::MAX_CHANNELS_IN,
   parameter int MAX_CHANNELS_OUT = crmp_pkg::MAX_CHANNELS_OUT,
   parameter int MAX_IMAGE_DIM    = crmp_pkg::MAX_IMAGE_DIM
) (
   input  logic         clock,
   input  logic         reset,
   crmp_req_if.sink     req_if,
   crmp_rsp_if.source   rsp_if,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   crmp_pkg::cfg_type    cfg;
   crmp_pkg::cmd_type    cmd;
   crmp_pkg::status_type status;

   crmp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   crmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   crmp_dp #(
      .MAX_CHANNELS_IN  (MAX_CHANNELS_IN),
      .MAX_CHANNELS_OUT (MAX_CHANNELS_OUT),
      .MAX_IMAGE_DIM    (MAX_IMAGE_DIM)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_if.kind),
      .req_store_index (req_if.store_index),
      .req_write_value (req_if.write_value),
      .req_out_channel (req_if.out_channel),
      .req_out_row     (req_if.out_row),
      .req_out_col     (req_if.out_col),
      .pixel_out       (rsp_if.pixel_out)
   );

endmodule

### tb/testbench.sv
// Self-checking bench for the 5x5 conv / ReLU / requant / max-pool core.
// Uses crmp_pkg and the crmp_req_if / crmp_rsp_if channels; loads stores and predicts pixels.
`timescale 1ns / 1ps

class pixel_predictor;
   byte         pixel_mem [16384];
   byte         weight_mem [12800];
   shortint     bias_mem [32];
   int unsigned in_channels, in_height, in_width, out_channels;
   int unsigned pad_amount, pool_enable, scale_factor, shift_amount;
   logic [6:0]  expected_pixels [$];
   int          errors;

   function new();
      in_channels  = 1;
      in_height    = 28;
      in_width     = 28;
      out_channels = 1;
      pad_amount   = 0;
      pool_enable  = 0;
      scale_factor = 65536;
      shift_amount = 0;
      errors       = 0;
   endfunction

   function void set_reg(logic [2:0] r, logic [31:0] v);
      case (r)
         crmp_pkg::REG_IN_CHANNELS:  in_channels  = v[4:0];
         crmp_pkg::REG_IN_HEIGHT:    in_height    = v[5:0];
         crmp_pkg::REG_IN_WIDTH:     in_width     = v[5:0];
         crmp_pkg::REG_OUT_CHANNELS: out_channels = v[5:0];
         crmp_pkg::REG_PAD_AMOUNT:   pad_amount   = v[1:0];
         crmp_pkg::REG_POOL_ENABLE:  pool_enable  = v[0];
         crmp_pkg::REG_SCALE_FACTOR: scale_factor = v[23:0];
         crmp_pkg::REG_SHIFT_AMOUNT: shift_amount = v[4:0];
         default: ;
      endcase
   endfunction

   function int unsigned conv_at(int co, int ho, int wo);
      int cin, h, w, pad, acc, hi, wi, iv, wv, widx, idx;
      longint unsigned prod;
      cin = (in_channels > 16) ? 16 : in_channels;
      h   = (in_height > 32) ? 32 : in_height;
      w   = (in_width > 32) ? 32 : in_width;
      pad = (pad_amount > 2) ? 2 : pad_amount;
      acc = bias_mem[co];
      for (int ci = 0; ci < cin; ci++) begin
         for (int kh = 0; kh < 5; kh++) begin
            for (int kw = 0; kw < 5; kw++) begin
               hi   = ho + kh - pad;
               wi   = wo + kw - pad;
               widx = (co * cin + ci) * 25 + kh * 5 + kw;
               wv   = (widx < 12800) ? weight_mem[widx] : 0;
               iv   = 0;
               if (hi >= 0 && hi < h && wi >= 0 && wi < w) begin
                  idx = (ci * h + hi) * w + wi;
                  iv  = (idx < 16384) ? pixel_mem[idx] : 0;
               end
               acc += iv * wv;
            end
         end
      end
      if (acc < 0) acc = 0;
      prod = (longint'(scale_factor) * longint'(acc)) >> 16;
      prod = prod >> shift_amount;
      return (prod > 127) ? 127 : int'(prod);
   endfunction

   // note one accepted item; compute items queue one pixel
   function void note_item(int kind, int idx, int val, int co, int row, int col);
      int unsigned r, t;
      case (kind[1:0])
         crmp_pkg::KIND_PIXEL:  pixel_mem[idx[13:0]] = val[7:0];
         crmp_pkg::KIND_WEIGHT: if (idx < 12800) weight_mem[idx] = val[7:0];
         crmp_pkg::KIND_BIAS:   if (idx < 32) bias_mem[idx] = val[15:0];
         default: begin
            if (pool_enable != 0) begin
               r = conv_at(co, row * 2, col * 2);
               t = conv_at(co, row * 2, col * 2 + 1);     if (t > r) r = t;
               t = conv_at(co, row * 2 + 1, col * 2);     if (t > r) r = t;
               t = conv_at(co, row * 2 + 1, col * 2 + 1); if (t > r) r = t;
            end else begin
               r = conv_at(co, row, col);
            end
            expected_pixels.push_back(r[6:0]);
         end
      endcase
   endfunction

   function void check_pixel(logic [6:0] got);
      logic [6:0] want;
      if (expected_pixels.size() == 0) begin
         $display("%0t: pixel transfer with none expected, actual %0d", $time, got);
         errors++;
      end else begin
         want = expected_pixels.pop_front();
         if (got !== want) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, want, got);
            errors++;
         end
      end
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 5000000;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;

   crmp_req_if req_if ();
   crmp_rsp_if rsp_if ();

   conv5x5_relu_requant_maxpool_core dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pixel_predictor pred;
   int  cycles = 0;
   int  req_gap = 0;
   bit  req_burst = 0;
   int  sent = 0;
   int  rsp_hold = 0;
   bit  rsp_burst = 0;
   int  cur_cin, cur_h, cur_w;
   int  loaded_co [$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: check each transfer, then hold ready low for a random stall, none in burst mode
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            pred.check_pixel(rsp_if.pixel_out);
            if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, 19);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_if.ready <= (rsp_hold == 0);
      end
   end

   task automatic send_item(int kind, int idx, int val, int co, int row, int col);
      if (req_gap > 0) repeat (req_gap) @(posedge clock);
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind[1:0];
      req_if.store_index <= idx[13:0];
      req_if.write_value <= val[15:0];
      req_if.out_channel <= co[4:0];
      req_if.out_row     <= row[4:0];
      req_if.out_col     <= col[4:0];
      do @(posedge clock); while (!req_if.ready);
      pred.note_item(kind, idx, val, co, row, col);
      sent++;
      if (sent % 64 == 0) req_burst = ($urandom_range(0, 3) == 0);
      req_gap = req_burst ? 0 : $urandom_range(0, 19);
      if (req_gap > 0) req_if.valid <= 1'b0;
   endtask

   task automatic drain();
      if (req_gap == 0) req_if.valid <= 1'b0;
      req_gap = 1;
      while (pred.expected_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic apply_config(int cin, int h, int w, int oc, int pad, int pool,
                               int scale, int shift);
      logic [31:0] vals [8];
      vals = '{cin, h, w, oc, pad, pool, scale, shift};
      for (int r = 0; r < 8; r++) begin
         psel    <= 1'b1;
         pwrite  <= 1'b1;
         penable <= 1'b0;
         paddr   <= {r[2:0], 2'b00};
         pwdata  <= vals[r];
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         pred.set_reg(r[2:0], vals[r]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      cur_cin = (cin > 16) ? 16 : cin;
      cur_h   = (h > 32) ? 32 : h;
      cur_w   = (w > 32) ? 32 : w;
   endtask

   // fill the image and the weights of ncos output channels
   task automatic load_planes(int ncos, bit with_top);
      int co;
      for (int i = 0; i < cur_cin * cur_h * cur_w; i++)
         send_item(crmp_pkg::KIND_PIXEL, i, $urandom_range(0, 65535), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 31));
      loaded_co = {};
      for (int k = 0; k < ncos; k++) begin
         co = (with_top && k == 0) ? 31 : $urandom_range(0, 31);
         loaded_co.push_back(co);
         for (int i = 0; i < cur_cin * 25; i++)
            send_item(crmp_pkg::KIND_WEIGHT, co * cur_cin * 25 + i, $urandom_range(0, 65535),
                      $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
      end
   endtask

   task automatic compute_at(int row, int col);
      send_item(crmp_pkg::KIND_COMPUTE, $urandom_range(0, 16383), $urandom_range(0, 65535),
                loaded_co[$urandom_range(0, loaded_co.size() - 1)], row, col);
   endtask

   task automatic random_mix(int n);
      int r, co;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            if ($urandom_range(0, 1) != 0)
               compute_at($urandom_range(0, 31), $urandom_range(0, 31));
            else
               compute_at($urandom_range(0, cur_h / 2), $urandom_range(0, cur_w / 2));
         end else if (r < 72 && cur_cin * cur_h * cur_w > 0) begin
            send_item(crmp_pkg::KIND_PIXEL, $urandom_range(0, cur_cin * cur_h * cur_w - 1),
                      $urandom_range(0, 65535), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 31));
         end else if (r < 85 && cur_cin > 0) begin
            co = loaded_co[$urandom_range(0, loaded_co.size() - 1)];
            send_item(crmp_pkg::KIND_WEIGHT,
                      co * cur_cin * 25 + $urandom_range(0, cur_cin * 25 - 1),
                      $urandom_range(0, 65535), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 31));
         end else if (r < 95) begin
            send_item(crmp_pkg::KIND_BIAS, $urandom_range(0, 31), $urandom_range(0, 65535),
                      $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
         end else begin
            // any store, any index; out-of-range weight and bias writes drop
            send_item($urandom_range(0, 2), $urandom_range(0, 16383),
                      $urandom_range(0, 65535), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 31));
         end
      end
   endtask

   task automatic fixed_phase(int cin, int h, int w, int oc, int pad, int pool,
                              int scale, int shift, int ncos, bit with_top);
      apply_config(cin, h, w, oc, pad, pool, scale, shift);
      load_planes(ncos, with_top);
      compute_at(0, 0);
      compute_at(31, 31);
      compute_at(31, 0);
      compute_at(0, 31);
      random_mix(8);
      drain();
   endtask

   initial begin
      pred = new();
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_if.valid   <= 1'b0;
      req_if.kind    <= crmp_pkg::KIND_PIXEL;
      req_if.store_index <= '0;
      req_if.write_value <= '0;
      req_if.out_channel <= '0;
      req_if.out_row <= '0;
      req_if.out_col <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // any bias can be read by a compute item, so load them all first
      send_item(crmp_pkg::KIND_BIAS, 0, 32767, 0, 0, 0);
      send_item(crmp_pkg::KIND_BIAS, 1, -32768, 31, 31, 31);
      for (int i = 2; i < 32; i++)
         send_item(crmp_pkg::KIND_BIAS, i, $urandom_range(0, 65535), 0, 0, 0);
      drain();

      fixed_phase(1, 5, 5, 1, 2, 0, 65536, 0, 2, 0);
      fixed_phase(2, 6, 7, 32, 1, 1, 16777215, 31, 2, 0);
      // no input channels: bias alone
      fixed_phase(0, 4, 4, 0, 0, 0, 200000, 3, 2, 0);
      // channel count and padding beyond range saturate
      fixed_phase(31, 2, 2, 63, 3, 0, 1000, 2, 1, 1);
      fixed_phase(1, 63, 2, 5, 0, 1, 30000, 8, 1, 0);
      // zero height: every tap is padding
      fixed_phase(3, 0, 9, 7, 1, 1, 5000000, 0, 2, 1);

      while (sent < 1750) begin
         apply_config($urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 3),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 10),
                      $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 10),
                      $urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 1),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 16777215)
                                                : $urandom_range(2000, 70000),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                : $urandom_range(6, 14));
         if (cur_cin * cur_h * cur_w > 600)
            apply_config(2, 8, 8, 2, $urandom_range(0, 3), $urandom_range(0, 1),
                         65536, 10);
         load_planes($urandom_range(1, 3), $urandom_range(0, 3) == 0);
         random_mix(150);
         drain();
      end

      if (pred.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

### sim.f
hdl/crmp_pkg.sv
hdl/crmp_if.sv
hdl/crmp_csr.sv
hdl/crmp_dp.sv
hdl/crmp_ctrl.sv
hdl/conv5x5_relu_requant_maxpool_core.sv
tb/testbench.sv
